@@ src/bpa_pkg.sv @@
// shared types, codes and constants for the bitmap page allocator
package bpa_pkg;

    localparam int MAP_WORDS_DEF = 256;
    localparam int WORD_BITS     = 32;
    localparam int PAGE_BYTES    = 4096;

    localparam logic [31:0] WORD_ONES = 32'hffff_ffff;

    // request kinds
    localparam logic [1:0] KIND_INIT     = 2'd0;
    localparam logic [1:0] KIND_GET_ONE  = 2'd1;
    localparam logic [1:0] KIND_PUT      = 2'd2;
    localparam logic [1:0] KIND_GET_MANY = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_OUT_OF_MAP = 2'd2;

    // bitmap write data select
    localparam logic [2:0] WR_ONES = 3'd0;
    localparam logic [2:0] WR_INIT = 3'd1;
    localparam logic [2:0] WR_TAKE = 3'd2;
    localparam logic [2:0] WR_PUT  = 3'd3;
    localparam logic [2:0] WR_RUN  = 3'd4;

    // result select
    localparam logic [2:0] RES_OK_ZERO  = 3'd0;
    localparam logic [2:0] RES_NO_SPACE = 3'd1;
    localparam logic [2:0] RES_OOB      = 3'd2;
    localparam logic [2:0] RES_ONE      = 3'd3;
    localparam logic [2:0] RES_MANY     = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] page_address;
        logic [4:0]  order;
    } bpa_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_address;
    } bpa_out_t;

    typedef struct packed {
        logic       load;
        logic       idx_clr;
        logic       step;
        logic       scan;
        logic       run_start;
        logic       rd_put;
        logic       we;
        logic [2:0] wr_sel;
        logic       res_we;
        logic [2:0] res_sel;
        logic       out_load;
    } bpa_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic scan_end;
        logic one_hit;
        logic many_hit;
        logic put_oob;
        logic run_last;
    } bpa_sts_t;

endpackage

@@ src/bpa_ram.sv @@
// generic simple dual-port ram with registered read
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/bpa_dp.sv @@
// allocator datapath: bitmap ram, scan counters, result registers
module bpa_dp #(
    parameter int MAP_WORDS = bpa_pkg::MAP_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [30:0]       cfg_data,
    input  bpa_pkg::bpa_in_t  in_data,
    input  bpa_pkg::bpa_cmd_t cmd,
    output bpa_pkg::bpa_sts_t sts,
    output bpa_pkg::bpa_out_t out_data
);
    import bpa_pkg::*;

    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW = $clog2(MAP_WORDS + 1);
    localparam logic [AW-1:0] LAST = AW'(MAP_WORDS - 1);

    logic [19:0]   rsv_reg;
    bpa_in_t       req_reg;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] chk_idx_reg;
    logic          chk_vld_reg;
    logic [CW-1:0] have_reg, have_next;
    logic [AW-1:0] start_reg;
    logic [AW-1:0] last_reg;
    bpa_out_t      res_reg, res_next;
    bpa_out_t      out_reg;

    logic [31:0]   rsv_sum;
    logic [31:0]   rd_data;
    logic [31:0]   wr_data;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [31:0]   init_word;
    logic [31:0]   run_word;
    logic [5:0]    run_cnt;
    logic [14:0]   idx_wide;
    logic [4:0]    lsb;
    logic          full;
    logic [CW-1:0] have_inc;
    logic [AW-1:0] start_eff;
    logic [26:0]   need;
    logic [18:0]   freed_page;
    logic [13:0]   put_word;
    logic [18:0]   one_page;
    logic [18:0]   many_page;

    // reserved page count, rounded up, computed once per register write
    assign rsv_sum = {1'b0, cfg_data} + 32'(PAGE_BYTES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsv_reg <= '0;
        end
        else if (cfg_we)
        begin
            rsv_reg <= rsv_sum[31:12];
        end
    end

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign freed_page = req_reg.page_address[30:12];
    assign put_word   = freed_page[18:5];

    // word pattern for init: in use below the reserved end
    assign idx_wide = 15'(idx_reg);
    always_comb
    begin
        if (idx_wide < rsv_reg[19:5])
        begin
            init_word = '0;
        end
        else if (idx_wide == rsv_reg[19:5])
        begin
            init_word = WORD_ONES << rsv_reg[4:0];
        end
        else
        begin
            init_word = WORD_ONES;
        end
    end

    // last word of a run below one full word keeps its upper bits free
    assign run_cnt = 6'd1 << req_reg.order[2:0];
    always_comb
    begin
        if ((idx_reg == last_reg) && (req_reg.order < 5'd5))
        begin
            run_word = WORD_ONES << run_cnt;
        end
        else
        begin
            run_word = '0;
        end
    end

    always_comb
    begin
        lsb = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (rd_data[i])
            begin
                lsb = 5'(i);
            end
        end
    end

    assign full      = (rd_data == WORD_ONES);
    assign have_inc  = have_reg + 1'b1;
    assign start_eff = (have_reg == '0) ? chk_idx_reg : start_reg;

    always_comb
    begin
        if (req_reg.order <= 5'd5)
        begin
            need = 27'd1;
        end
        else
        begin
            need = 27'd1 << (req_reg.order - 5'd5);
        end
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_ONES:
            begin
                waddr   = idx_reg;
                wr_data = WORD_ONES;
            end
            WR_INIT:
            begin
                waddr   = idx_reg;
                wr_data = init_word;
            end
            WR_TAKE:
            begin
                waddr   = chk_idx_reg;
                wr_data = rd_data & (rd_data - 32'd1);
            end
            WR_PUT:
            begin
                waddr   = AW'(put_word);
                wr_data = rd_data | (32'd1 << freed_page[4:0]);
            end
            WR_RUN:
            begin
                waddr   = idx_reg;
                wr_data = run_word;
            end
            default:
            begin
                waddr   = idx_reg;
                wr_data = WORD_ONES;
            end
        endcase
    end

    assign raddr = cmd.rd_put ? AW'(put_word) : idx_reg;

    assign one_page  = 19'({chk_idx_reg, lsb});
    assign many_page = 19'({start_eff, 5'b0});

    always_comb
    begin
        res_next.status         = ST_OK;
        res_next.result_address = '0;
        unique case (cmd.res_sel)
            RES_OK_ZERO:  res_next.status = ST_OK;
            RES_NO_SPACE: res_next.status = ST_NO_SPACE;
            RES_OOB:      res_next.status = ST_OUT_OF_MAP;
            RES_ONE:      res_next.result_address = {1'b1, one_page, 12'b0};
            RES_MANY:     res_next.result_address = {1'b1, many_page, 12'b0};
            default:      res_next.status = ST_OK;
        endcase
    end

    always_comb
    begin
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.run_start)
        begin
            idx_next = start_eff;
        end
        else if (cmd.step && (idx_reg != LAST))
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_comb
    begin
        if (cmd.idx_clr)
        begin
            have_next = '0;
        end
        else if (chk_vld_reg)
        begin
            have_next = full ? have_inc : '0;
        end
        else
        begin
            have_next = have_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            chk_vld_reg <= 1'b0;
            have_reg    <= '0;
        end
        else
        begin
            idx_reg     <= idx_next;
            chk_vld_reg <= cmd.scan;
            have_reg    <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= idx_reg;
        if (chk_vld_reg && full)
        begin
            start_reg <= start_eff;
        end
        if (cmd.run_start)
        begin
            last_reg <= chk_idx_reg;
        end
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
        if (cmd.res_we)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign sts.sweep_last = (idx_reg == LAST);
    assign sts.scan_end   = chk_vld_reg && (chk_idx_reg == LAST);
    assign sts.one_hit    = chk_vld_reg && (rd_data != '0);
    assign sts.many_hit   = chk_vld_reg && full && (27'(have_inc) == need);
    assign sts.put_oob    = (32'(put_word) >= 32'(MAP_WORDS));
    assign sts.run_last   = (idx_reg == last_reg);

    assign out_data = out_reg;

endmodule

@@ src/bpa_ctrl.sv @@
// allocator controller: request sequencing and output handshake
module bpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_kind,
    output logic              out_valid,
    input  logic              out_ready,
    input  bpa_pkg::bpa_sts_t sts,
    output bpa_pkg::bpa_cmd_t cmd
);
    import bpa_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_INIT   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;
    localparam logic [2:0] S_PUT_WR = 3'd5;
    localparam logic [2:0] S_ALLOC  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] kind_reg;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.wr_sel     = WR_ONES;
        cmd.res_sel    = RES_OK_ZERO;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.we   = 1'b1;
                cmd.step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    unique case (in_kind)
                        KIND_INIT: state_next = S_INIT;
                        KIND_PUT:  state_next = S_PUT;
                        default:   state_next = S_SCAN;
                    endcase
                end
            end
            S_INIT:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = WR_INIT;
                cmd.step   = 1'b1;
                if (sts.sweep_last)
                begin
                    cmd.res_we = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                cmd.scan = 1'b1;
                if (kind_reg == KIND_GET_ONE)
                begin
                    if (sts.one_hit)
                    begin
                        cmd.we      = 1'b1;
                        cmd.wr_sel  = WR_TAKE;
                        cmd.res_we  = 1'b1;
                        cmd.res_sel = RES_ONE;
                        state_next  = S_DONE;
                    end
                    else if (sts.scan_end)
                    begin
                        cmd.res_we  = 1'b1;
                        cmd.res_sel = RES_NO_SPACE;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    if (sts.many_hit)
                    begin
                        cmd.run_start = 1'b1;
                        cmd.res_we    = 1'b1;
                        cmd.res_sel   = RES_MANY;
                        state_next    = S_ALLOC;
                    end
                    else if (sts.scan_end)
                    begin
                        cmd.res_we  = 1'b1;
                        cmd.res_sel = RES_NO_SPACE;
                        state_next  = S_DONE;
                    end
                end
            end
            S_PUT:
            begin
                if (sts.put_oob)
                begin
                    cmd.res_we  = 1'b1;
                    cmd.res_sel = RES_OOB;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_put = 1'b1;
                    state_next = S_PUT_WR;
                end
            end
            S_PUT_WR:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = WR_PUT;
                cmd.res_we = 1'b1;
                state_next = S_DONE;
            end
            S_ALLOC:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = WR_RUN;
                cmd.step   = 1'b1;
                if (sts.run_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            kind_reg      <= KIND_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                kind_reg <= in_kind;
            end
        end
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !cmd.we)
        else $error("bitmap written while idle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted word did not start a request");

    a_take_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && kind_reg == KIND_GET_ONE && sts.one_hit)
        |=> (state_reg == S_DONE))
        else $error("single page hit did not finish the request");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

endmodule

@@ src/bitmap_page_allocator.sv @@
// bitmap page allocator top level
// Tracks MAP_WORDS*32 pages of 4 KiB in a one-port-read, one-port-write ram of
// 32-bit words (bit set = page free). After reset a clearing pass writes ones to
// every word of the map; no request word is taken until it ends, while register
// writes are taken at any time. One request is handled at a time; the result
// goes to an output register so the next request word can be taken while it
// waits. Each request walks the ram one word per cycle: init rewrites every
// word, get-one scans until it finds a free bit, put reads and rewrites one
// word (neither when the address is outside the map), get-many scans for a run
// of fully free words and then clears the words of that run.
module bitmap_page_allocator #(
    parameter int MAP_WORDS = bpa_pkg::MAP_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bpa_pkg::bpa_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output bpa_pkg::bpa_out_t out_data,
    input  logic             cfg_we,
    input  logic [30:0]      cfg_data
);
    import bpa_pkg::*;

    bpa_cmd_t cmd;
    bpa_sts_t sts;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_kind   (in_data.kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpa_dp #(
        .MAP_WORDS (MAP_WORDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

@@ sim/bitmap_page_allocator_tb.sv @@
// self-checking testbench for the bitmap page allocator: directed and random requests
module bitmap_page_allocator_tb;
    import bpa_pkg::*;

    localparam int MAP_WORDS    = MAP_WORDS_DEF;
    localparam int MAP_PAGES    = MAP_WORDS * WORD_BITS;
    localparam int SETTLE_LIMIT = 2 * MAP_WORDS + 8;
    localparam int STALL_LIMIT  = 10000;
    localparam int LONG_HOLD    = 1500;
    localparam logic [31:0] MEM_BASE = 32'h8000_0000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    bpa_in_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    bpa_out_t    out_data;
    logic        cfg_we = 1'b0;
    logic [30:0] cfg_data = '0;

    // allocator model state
    logic [31:0] free_map [MAP_WORDS];
    logic [30:0] reserved_end = '0;

    bpa_out_t    pending_results[$];
    logic [31:0] held_pages[$];
    bpa_out_t    oldest_result;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    logic        valid_on = 1'b0;
    int          hold_request = 0;
    int          hold_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;

    bitmap_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            free_map[w] = WORD_ONES;
        end
    end

    function automatic bpa_out_t predict_request(bpa_in_t req);
        bpa_out_t res;
        longint   reserved;
        longint   page;
        longint   pages;
        longint   need;
        longint   have;
        longint   start;
        longint   rem;
        int       w;
        int       b;
        res.status = ST_OK;
        res.result_address = '0;
        case (req.kind)
            KIND_INIT:
            begin
                reserved = (longint'(reserved_end) + PAGE_BYTES - 1) / PAGE_BYTES;
                if (reserved > MAP_PAGES)
                    reserved = MAP_PAGES;
                for (w = 0; w < MAP_WORDS; w++)
                    free_map[w] = WORD_ONES;
                for (page = 0; page < reserved; page++)
                    free_map[page / WORD_BITS][page % WORD_BITS] = 1'b0;
            end
            KIND_GET_ONE:
            begin
                res.status = ST_NO_SPACE;
                for (w = 0; w < MAP_WORDS && res.status != ST_OK; w++)
                begin
                    if (free_map[w] != '0)
                    begin
                        for (b = 0; b < WORD_BITS; b++)
                            if (free_map[w][b])
                                break;
                        free_map[w][b] = 1'b0;
                        res.status = ST_OK;
                        res.result_address = MEM_BASE + 32'((w * WORD_BITS + b) * PAGE_BYTES);
                    end
                end
            end
            KIND_PUT:
            begin
                page = longint'(req.page_address[30:12]);
                if (page >= MAP_PAGES)
                    res.status = ST_OUT_OF_MAP;
                else
                    free_map[page / WORD_BITS][page % WORD_BITS] = 1'b1;
            end
            KIND_GET_MANY:
            begin
                pages = longint'(1) << req.order;
                need = (pages - 1) / WORD_BITS + 1;
                have = 0;
                start = 0;
                // first run of fully free words, even for requests under one word
                for (w = 0; w < MAP_WORDS; w++)
                begin
                    if (free_map[w] == WORD_ONES)
                    begin
                        if (have == 0)
                            start = w;
                        have++;
                        if (have == need)
                            break;
                    end
                    else
                    begin
                        have = 0;
                    end
                end
                if (have < need)
                begin
                    res.status = ST_NO_SPACE;
                end
                else
                begin
                    for (page = start; page < start + have - 1; page++)
                        free_map[page] = '0;
                    rem = pages - (have - 1) * WORD_BITS;
                    if (rem >= WORD_BITS)
                        free_map[start + have - 1] = '0;
                    else
                        free_map[start + have - 1] &= ~((32'd1 << rem) - 32'd1);
                    res.result_address = MEM_BASE + 32'(start * WORD_BITS * PAGE_BYTES);
                end
            end
        endcase
        return res;
    endfunction

    function automatic bpa_in_t make_req(logic [1:0] kind, logic [31:0] addr, logic [4:0] order);
        bpa_in_t req;
        req.kind = kind;
        req.page_address = addr;
        req.order = order;
        return req;
    endfunction

    function automatic bpa_in_t random_request();
        bpa_in_t     req;
        int          pick;
        int          idx;
        logic [31:0] addr;
        pick = $urandom_range(0, 99);
        req.page_address = $urandom;
        req.order = 5'($urandom_range(0, 31));
        if (pick < 35)
        begin
            req.kind = KIND_GET_ONE;
        end
        else if (pick < 65)
        begin
            req.kind = KIND_PUT;
            if (held_pages.size() > 0 && $urandom_range(0, 9) != 0)
            begin
                idx = $urandom_range(0, held_pages.size() - 1);
                addr = held_pages[idx];
                held_pages.delete(idx);
                req.page_address = {1'($urandom), addr[30:12], 12'($urandom)};
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                req.page_address = {1'($urandom), 6'd0, 13'($urandom), 12'($urandom)};
            end
        end
        else if (pick < 95)
        begin
            req.kind = KIND_GET_MANY;
            if ($urandom_range(0, 7) != 0)
                req.order = 5'($urandom_range(0, 6));
        end
        else
        begin
            req.kind = KIND_INIT;
        end
        return req;
    endfunction

    task automatic send_word(input bpa_in_t req);
        bpa_out_t result;
        int       gap;
        int       sel;
        in_valid <= 1'b1;
        in_data <= req;
        valid_on = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        result = predict_request(req);
        pending_results.push_back(result);
        // remember pages that are in use so later puts hit real allocations
        if (req.kind == KIND_INIT)
        begin
            held_pages.delete();
        end
        else if (result.status == ST_OK && req.kind == KIND_GET_ONE)
        begin
            held_pages.push_back(result.result_address);
        end
        else if (result.status == ST_OK && req.kind == KIND_GET_MANY)
        begin
            held_pages.push_back(result.result_address);
            repeat (2)
                held_pages.push_back(result.result_address +
                    32'($urandom_range(0, (1 << req.order) - 1) * PAGE_BYTES));
        end
        while (held_pages.size() > 400)
            void'(held_pages.pop_front());
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 40);
            sel = $urandom_range(0, 9);
            if (sel < 3)
                gap = 0;
            else if (sel < 8)
                gap = $urandom_range(1, 12);
            else if (sel < 9)
                gap = $urandom_range(20, 80);
            else
                gap = $urandom_range(100, 300);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                valid_on = 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        if (valid_on)
        begin
            in_valid <= 1'b0;
            valid_on = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LIMIT)
            @(posedge clk);
    endtask

    task automatic write_reserved_end(input logic [30:0] offset);
        drain_results();
        cfg_we <= 1'b1;
        cfg_data <= offset;
        reserved_end = offset;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // map as left by reset, then a zero-reserve init
    task automatic test_fresh_map();
        send_word(make_req(KIND_GET_ONE, '0, '0));
        send_word(make_req(KIND_GET_ONE, '1, '1));
        send_word(make_req(KIND_PUT, 32'h0000_0000, '0));
        send_word(make_req(KIND_PUT, 32'h8000_5abc, 5'd31));
        send_word(make_req(KIND_PUT, 32'h01ff_f000, '0));
        send_word(make_req(KIND_PUT, 32'h0200_0000, '0));
        send_word(make_req(KIND_PUT, 32'hffff_ffff, '1));
        send_word(make_req(KIND_GET_MANY, '0, 5'd0));
        send_word(make_req(KIND_GET_MANY, '0, 5'd5));
        send_word(make_req(KIND_GET_MANY, '1, 5'd6));
        send_word(make_req(KIND_GET_MANY, '0, 5'd31));
        send_word(make_req(KIND_INIT, '1, '1));
        send_word(make_req(KIND_GET_MANY, '0, 5'd13));
        send_word(make_req(KIND_GET_ONE, '0, '0));
        send_word(make_req(KIND_GET_MANY, '0, 5'd0));
    endtask

    task automatic test_reserved_end();
        write_reserved_end(31'h7fff_ffff);
        send_word(make_req(KIND_INIT, '0, '0));
        send_word(make_req(KIND_GET_ONE, '0, '0));
        send_word(make_req(KIND_PUT, 32'h8000_3000, '0));
        send_word(make_req(KIND_GET_ONE, '0, '0));
        write_reserved_end(31'd1);
        send_word(make_req(KIND_INIT, '0, '0));
        send_word(make_req(KIND_GET_ONE, '0, '0));
        write_reserved_end(31'd4096);
        send_word(make_req(KIND_INIT, '0, '0));
        send_word(make_req(KIND_GET_ONE, '0, '0));
        write_reserved_end(31'(MAP_PAGES * PAGE_BYTES));
        send_word(make_req(KIND_INIT, '0, '0));
        send_word(make_req(KIND_GET_MANY, '0, 5'd0));
    endtask

    task automatic test_random_traffic();
        logic [30:0] offset;
        for (int phase = 0; phase < 11; phase++)
        begin
            case (phase % 5)
                0: offset = '0;
                1: offset = 31'($urandom_range(0, 32'h7fff_ffff));
                2: offset = 31'((MAP_PAGES - $urandom_range(0, 200)) * PAGE_BYTES
                               - $urandom_range(0, PAGE_BYTES - 1));
                3: offset = 31'($urandom_range(0, 200 * PAGE_BYTES));
                default: offset = (phase == 4) ? 31'h7fff_ffff : 31'($urandom_range(0, 4095));
            endcase
            write_reserved_end(offset);
            send_word(make_req(KIND_INIT, $urandom, 5'($urandom)));
            repeat (100)
                send_word(random_request());
        end
    endtask

    // receiver holds off long enough that the block backs up into its input
    task automatic test_output_backpressure();
        write_reserved_end(31'($urandom_range(0, 64 * PAGE_BYTES)));
        send_word(make_req(KIND_INIT, '0, '0));
        hold_request = LONG_HOLD;
        burst_left = 50;
        repeat (45)
            send_word(random_request());
        drain_results();
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        test_fresh_map();
        test_reserved_end();
        test_random_traffic();
        test_output_backpressure();
        drain_results();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 400);
        end
        mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((mode_left % 16) < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing pending: status %0d address %h",
                       out_data.status, out_data.result_address);
                fail_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (out_data.status !== oldest_result.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           oldest_result.status, out_data.status);
                    fail_count++;
                end
                if (out_data.result_address !== oldest_result.result_address)
                begin
                    $error("result_address: expected %h, actual %h",
                           oldest_result.result_address, out_data.result_address);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
